// File: hw/rtl/mgde_pkg.sv
package mgde_pkg;

    localparam int REGS_PER_CH = 7;
    localparam int MAX_OUT     = 32;

    localparam logic [1:0] MODE_REG_WR = 2'd0;
    localparam logic [1:0] MODE_EN_WR  = 2'd1;
    localparam logic [1:0] MODE_TICK   = 2'd2;

    typedef struct packed {
        logic [1:0] mode;
        logic [2:0] channel;
        logic [2:0] reg_index;
        logic [7:0] write_value;
        logic [7:0] cycles;
        logic       hdma_busy;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  xfer_channel;
        logic [23:0] a_bus_addr;
        logic [13:0] b_bus_addr;
        logic        to_peripheral;
        logic [7:0]  enable_after;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [23:0] addr;
        logic [16:0] count;
        logic [1:0]  step;
        logic        dir;
        logic [2:0]  pattern;
        logic [1:0]  phase;
        logic [7:0]  bbus;
    } t_work;

endpackage

// File: hw/rtl/mgde_regfile.sv
module mgde_regfile #(
    parameter int NUM_CHANNELS = 8,
    localparam int RF_DEPTH = NUM_CHANNELS * mgde_pkg::REGS_PER_CH,
    localparam int RF_AW = $clog2(RF_DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_we,
    input  logic [RF_AW-1:0] i_waddr,
    input  logic [7:0]       i_wdata,
    input  logic [RF_AW-1:0] i_raddr,
    output logic [7:0]       o_rdata
);
    import mgde_pkg::*;

    logic [7:0]          r_mem [RF_DEPTH];
    logic [RF_DEPTH-1:0] r_valid;
    logic [7:0]          r_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_valid[i_raddr] ? r_mem[i_raddr] : 8'd0;
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/mgde_workmem.sv
module mgde_workmem #(
    parameter int NUM_CHANNELS = 8,
    localparam int CH_AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [CH_AW-1:0]      i_waddr,
    input  mgde_pkg::t_work       i_wdata,
    input  logic [CH_AW-1:0]      i_raddr,
    output mgde_pkg::t_work       o_rdata
);
    import mgde_pkg::*;

    t_work r_mem [NUM_CHANNELS];
    t_work r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/mgde_ctrl.sv
module mgde_ctrl #(
    parameter int NUM_CHANNELS    = 8,
    parameter int CYCLES_PER_BYTE = 8,
    parameter int BBUS_BASE       = 8448,
    localparam int RF_AW = $clog2(NUM_CHANNELS * mgde_pkg::REGS_PER_CH),
    localparam int CH_AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  mgde_pkg::t_in_item    i_in,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    output mgde_pkg::t_out_item   o_out,
    input  logic                  i_out_ready,
    output logic                  o_rf_we,
    output logic [RF_AW-1:0]      o_rf_waddr,
    output logic [7:0]            o_rf_wdata,
    output logic [RF_AW-1:0]      o_rf_raddr,
    input  logic [7:0]            i_rf_rdata,
    output logic                  o_wm_we,
    output logic [CH_AW-1:0]      o_wm_waddr,
    output mgde_pkg::t_work       o_wm_wdata,
    output logic [CH_AW-1:0]      o_wm_raddr,
    input  mgde_pkg::t_work       i_wm_rdata
);
    import mgde_pkg::*;

    localparam logic [7:0] CHAN_BITS = 8'((1 << NUM_CHANNELS) - 1);
    localparam int DIV_SHIFT = 17;
    localparam logic [17:0] RECIP =
        18'((2 ** DIV_SHIFT + CYCLES_PER_BYTE - 1) / CYCLES_PER_BYTE);
    localparam logic [6:0] CPB = 7'(CYCLES_PER_BYTE);
    localparam logic [16:0] BASE = 17'(BBUS_BASE);
    localparam logic [1:0] STEP_INC = 2'd0;
    localparam logic [1:0] STEP_DEC = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LATCH,
        S_DIV,
        S_REM,
        S_XFER
    } t_state;

    function automatic logic [2:0] lowest(input logic [7:0] v);
        logic [2:0] idx;
        idx = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (v[i]) begin
                idx = 3'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic [5:0] rf_addr(input logic [2:0] ch, input logic [2:0] idx);
        return {ch, 3'b000} - {3'b000, ch} + {3'b000, idx};
    endfunction

    function automatic logic [1:0] pat_off(input logic [2:0] pattern, input logic [1:0] phase);
        logic [1:0] off;
        case (pattern)
            3'd1, 3'd5: off = {1'b0, phase[0]};
            3'd3, 3'd7: off = {1'b0, phase[1]};
            3'd4:       off = phase;
            default:    off = 2'd0;
        endcase
        return off;
    endfunction

    t_state     r_state;
    logic [7:0] r_mask;
    logic [7:0] r_pend;
    logic [2:0] r_k;
    logic [47:0] r_asm;
    logic [8:0] r_accum;
    logic [9:0] r_sum;
    logic [9:0] r_q;
    logic [5:0] r_n;
    logic [2:0] r_ch;
    t_work      r_cur;
    logic       r_out_valid;
    t_out_item  r_out;

    logic        accept;
    logic [2:0]  lat_ch;
    logic [2:0]  tick_ch;
    logic [7:0]  lat_bit;
    t_work       lat_word;
    logic [15:0] lat_cnt;
    logic [27:0] div_prod;
    logic [16:0] rem_prod;
    logic [9:0]  rem;
    logic [5:0]  n_lim;
    logic [5:0]  n_clamp;
    logic        out_free;
    logic [15:0] n_lo;
    t_work       n_cur;
    logic [7:0]  n_mask;
    logic [16:0] bb_sum;
    t_out_item   n_out;

    assign accept  = i_in_valid && (r_state == S_IDLE);
    assign lat_ch  = lowest(r_pend);
    assign tick_ch = lowest(r_mask);
    assign lat_bit = 8'd1 << lat_ch;

    assign lat_cnt = {i_rf_rdata, r_asm[47:40]};
    always_comb begin
        lat_word.pattern = r_asm[2:0];
        lat_word.step    = r_asm[4:3];
        lat_word.dir     = r_asm[7];
        lat_word.phase   = 2'd0;
        lat_word.bbus    = r_asm[15:8];
        lat_word.addr    = r_asm[39:16];
        lat_word.count   = (lat_cnt == 16'd0) ? 17'h10000 : {1'b0, lat_cnt};
    end

    assign div_prod = r_sum * RECIP;
    assign rem_prod = r_q * CPB;
    assign rem      = r_sum - rem_prod[9:0];
    assign n_lim    = (r_q > 10'(MAX_OUT)) ? 6'(MAX_OUT) : r_q[5:0];
    assign n_clamp  = ({11'd0, n_lim} > i_wm_rdata.count) ? i_wm_rdata.count[5:0] : n_lim;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        case (r_cur.step)
            STEP_INC: n_lo = r_cur.addr[15:0] + 16'd1;
            STEP_DEC: n_lo = r_cur.addr[15:0] - 16'd1;
            default:  n_lo = r_cur.addr[15:0];
        endcase
        n_cur       = r_cur;
        n_cur.addr  = {r_cur.addr[23:16], n_lo};
        n_cur.phase = r_cur.phase + 2'd1;
        n_cur.count = r_cur.count - 17'd1;
        n_mask      = (n_cur.count == 17'd0) ? (r_mask & ~(8'd1 << r_ch)) : r_mask;
        bb_sum      = BASE + {9'd0, r_cur.bbus} + {15'd0, pat_off(r_cur.pattern, r_cur.phase)};
        n_out.xfer_channel  = r_ch;
        n_out.a_bus_addr    = r_cur.addr;
        n_out.b_bus_addr    = bb_sum[13:0];
        n_out.to_peripheral = ~r_cur.dir;
        n_out.enable_after  = n_mask;
        n_out.last          = (r_n == 6'd1);
    end

    assign o_rf_we    = accept && (i_in.mode == MODE_REG_WR)
                        && (int'(i_in.channel) < NUM_CHANNELS)
                        && (int'(i_in.reg_index) < REGS_PER_CH);
    assign o_rf_waddr = RF_AW'(rf_addr(i_in.channel, i_in.reg_index));
    assign o_rf_wdata = i_in.write_value;
    assign o_rf_raddr = RF_AW'(rf_addr(lat_ch, (r_k == 3'd7) ? 3'd6 : r_k));

    assign o_wm_we    = ((r_state == S_LATCH) && (r_k == 3'd7))
                        || ((r_state == S_XFER) && out_free && (r_n == 6'd1));
    assign o_wm_waddr = (r_state == S_LATCH) ? CH_AW'(lat_ch) : CH_AW'(r_ch);
    assign o_wm_wdata = (r_state == S_LATCH) ? lat_word : n_cur;
    assign o_wm_raddr = CH_AW'(tick_ch);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mask      <= 8'd0;
            r_pend      <= 8'd0;
            r_k         <= 3'd0;
            r_accum     <= 9'd0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state != S_XFER) && r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        case (i_in.mode)
                            MODE_EN_WR: begin
                                r_mask <= i_in.write_value & CHAN_BITS;
                                r_pend <= i_in.write_value & CHAN_BITS;
                                r_k    <= 3'd0;
                                if ((i_in.write_value & CHAN_BITS) != 8'd0) begin
                                    r_state <= S_LATCH;
                                end
                            end
                            MODE_TICK: begin
                                if ((r_mask != 8'd0) && !i_in.hdma_busy) begin
                                    r_sum   <= {1'b0, r_accum} + {2'b00, i_in.cycles};
                                    r_state <= S_DIV;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_LATCH: begin
                    r_asm <= {i_rf_rdata, r_asm[47:8]};
                    r_k   <= r_k + 3'd1;
                    if (r_k == 3'd7) begin
                        r_pend <= r_pend & ~lat_bit;
                        if ((r_pend & ~lat_bit) == 8'd0) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_DIV: begin
                    r_q     <= div_prod[DIV_SHIFT +: 10];
                    r_ch    <= tick_ch;
                    r_state <= S_REM;
                end
                S_REM: begin
                    r_accum <= rem[8:0];
                    r_cur   <= i_wm_rdata;
                    r_n     <= n_clamp;
                    r_state <= (r_q == 10'd0) ? S_IDLE : S_XFER;
                end
                S_XFER: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out       <= n_out;
                        r_cur       <= n_cur;
                        r_mask      <= n_mask;
                        r_n         <= r_n - 6'd1;
                        if (r_n == 6'd1) begin
                            r_state <= S_IDLE;
                            if (n_mask == 8'd0) begin
                                r_accum <= 9'd0;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// File: hw/rtl/multichannel_general_dma_engine.sv
// Multichannel DMA engine. The input channel carries one transaction per command:
// a channel register write, an enable mask write, or a time tick with elapsed cycles.
// The output channel carries one transaction per transferred byte, with the channel,
// both bus addresses, the direction, the enable mask after the byte and a last flag
// on the final byte of a tick.
// A register write goes straight to the channel register memory. An enable write
// is bounded by the seven reads of the channel register memory per enabled channel.
// A tick that moves bytes passes a divide and a remainder state before its first
// result, then yields one byte per cycle while the receiver does not stall, up to 32
// bytes, bounded by the single read-modify-write of the working state memory.
// Only one command is in progress at a time; a new one is taken once the last result
// of the previous one sits in the output register.
// Reset clears all enables, the cycle accumulator and the channel registers; no
// clearing pass is needed. When the receiver stalls, the output register holds its
// transaction and the engine waits with the remaining bytes.
module multichannel_general_dma_engine #(
    parameter int NUM_CHANNELS    = 8,
    parameter int CYCLES_PER_BYTE = 8,
    parameter int BBUS_BASE       = 8448
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  mgde_pkg::t_in_item    i_in,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    output mgde_pkg::t_out_item   o_out,
    input  logic                  i_out_ready
);
    import mgde_pkg::*;

    localparam int RF_AW = $clog2(NUM_CHANNELS * REGS_PER_CH);
    localparam int CH_AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic             rf_we;
    logic [RF_AW-1:0] rf_waddr;
    logic [7:0]       rf_wdata;
    logic [RF_AW-1:0] rf_raddr;
    logic [7:0]       rf_rdata;
    logic             wm_we;
    logic [CH_AW-1:0] wm_waddr;
    t_work            wm_wdata;
    logic [CH_AW-1:0] wm_raddr;
    t_work            wm_rdata;

    mgde_regfile #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_regfile (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (rf_we),
        .i_waddr (rf_waddr),
        .i_wdata (rf_wdata),
        .i_raddr (rf_raddr),
        .o_rdata (rf_rdata)
    );

    mgde_workmem #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_workmem (
        .i_clk   (i_clk),
        .i_we    (wm_we),
        .i_waddr (wm_waddr),
        .i_wdata (wm_wdata),
        .i_raddr (wm_raddr),
        .o_rdata (wm_rdata)
    );

    mgde_ctrl #(
        .NUM_CHANNELS    (NUM_CHANNELS),
        .CYCLES_PER_BYTE (CYCLES_PER_BYTE),
        .BBUS_BASE       (BBUS_BASE)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_ready (i_out_ready),
        .o_rf_we     (rf_we),
        .o_rf_waddr  (rf_waddr),
        .o_rf_wdata  (rf_wdata),
        .o_rf_raddr  (rf_raddr),
        .i_rf_rdata  (rf_rdata),
        .o_wm_we     (wm_we),
        .o_wm_waddr  (wm_waddr),
        .o_wm_wdata  (wm_wdata),
        .o_wm_raddr  (wm_raddr),
        .i_wm_rdata  (wm_rdata)
    );

endmodule
